FILE: src/langevin_momentum_propagator_macros.svh
// Assertion macros for the Langevin momentum propagator.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef LANGEVIN_MOMENTUM_PROPAGATOR_MACROS_SVH
`define LANGEVIN_MOMENTUM_PROPAGATOR_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent holds, consequent holds in the same cycle.
`define LMP_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Antecedent holds, consequent holds in the next cycle.
`define LMP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define LMP_ASSERT_SAME(name, ante, cons)
`define LMP_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: src/lmp_pkg.sv
// Shared types, codes and arithmetic helpers of the Langevin momentum propagator.
// No dependencies; used by the control, datapath and top-level files.
package lmp_pkg;

  // Field widths fixed by the interface.
  localparam int CFG_W   = 4;
  localparam int IDX_W   = 3;
  localparam int COEFF_W = 32;
  localparam int MOM_W   = 32;
  localparam int NOISE_W = 16;
  localparam int ACC_W   = 64;
  localparam int OP_W    = 2;
  localparam int MAX_LEN = 8;
  localparam logic [CFG_W-1:0] LEN_RESET = 4'd5;

  // Input opcodes.
  localparam logic [OP_W-1:0] OP_DRIFT = 2'd0;
  localparam logic [OP_W-1:0] OP_NOISE = 2'd1;
  localparam logic [OP_W-1:0] OP_PROP  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_SQUARE,
    ST_SQ_DRAIN,
    ST_EMIT
  } lmp_state_t;

  // Operation kinds sent through the shared multiplier.
  typedef enum logic [1:0] {
    K_DRIFT,
    K_NOISE,
    K_PSQ,
    K_O0SQ
  } lmp_kind_t;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    logic             t_we;
    logic             s_we;
    logic             issue_valid;
    lmp_kind_t        issue_kind;
    logic [IDX_W-1:0] issue_row;
    logic             load_item;
    logic             load_o0;
    logic             emit_valid;
    logic [IDX_W-1:0] emit_row;
    logic             emit_last;
    logic             clear;
  } lmp_ctrl_t;

  // Signed 64-bit add that clamps at the limits.
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic [64:0]        s;
    logic signed [63:0] res;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      res = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      res = $signed(s[63:0]);
    end
    return res;
  endfunction

  // Q.46 accumulator to Q16.16: shift by 30, round half up, saturate.
  function automatic logic signed [31:0] to_q16(input logic signed [63:0] acc);
    logic signed [63:0] sh;
    logic signed [34:0] r;
    logic signed [31:0] res;
    sh = acc >>> 30;
    r  = $signed(sh[34:0]) + $signed({34'd0, acc[29]});
    if (r > $signed(35'h0_7FFF_FFFF)) begin
      res = 32'sh7FFF_FFFF;
    end else if (r < $signed(35'h7_8000_0000)) begin
      res = 32'sh8000_0000;
    end else begin
      res = r[31:0];
    end
    return res;
  endfunction

endpackage

FILE: src/lmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the drift and noise matrices.
module lmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/lmp_ctrl.sv
// Sequencer of the Langevin momentum propagator: length register, item intake,
// multiply scheduling and result emission. Depends on lmp_pkg.
module lmp_ctrl #(
  parameter int MAX_VECTOR = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [lmp_pkg::OP_W-1:0]          opcode,
  input  logic [lmp_pkg::IDX_W-1:0]         row,
  input  logic [lmp_pkg::IDX_W-1:0]         col,
  input  logic                              cfg_valid,
  input  logic [lmp_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              pipe_busy,
  output logic                              busy,
  output logic                              cfg_ready,
  output logic [$clog2(MAX_VECTOR*MAX_VECTOR)-1:0] wr_addr,
  output logic [$clog2(MAX_VECTOR*MAX_VECTOR)-1:0] rd_addr,
  output lmp_pkg::lmp_ctrl_t                ctrl
);

  localparam int AW      = $clog2(MAX_VECTOR * MAX_VECTOR);
  localparam int LEN_CAP = (MAX_VECTOR < lmp_pkg::MAX_LEN) ? MAX_VECTOR : lmp_pkg::MAX_LEN;
  localparam int K_W     = 5;

  lmp_pkg::lmp_state_t state, state_next;
  logic [lmp_pkg::CFG_W-1:0] len_reg;
  logic [lmp_pkg::IDX_W-1:0] col_reg;
  logic [K_W-1:0]            k;
  logic [lmp_pkg::IDX_W-1:0] emit_idx;

  logic [lmp_pkg::CFG_W-1:0] len_eff;
  logic [lmp_pkg::IDX_W-1:0] len_m1;
  logic [K_W-1:0]            k_last;
  logic                      accept;
  logic                      prop_go;
  logic                      in_range;
  logic                      cfg_write;

  // Effective vector length, clamped to one through the capacity.
  always_comb begin
    if (len_reg == '0) begin
      len_eff = 4'd1;
    end else if (int'(len_reg) > LEN_CAP) begin
      len_eff = 4'(LEN_CAP);
    end else begin
      len_eff = len_reg;
    end
    len_m1 = 3'(len_eff - 4'd1);
    // Two products per row, plus the square of element zero when it arrives.
    k_last = {len_eff, 1'b0} - ((col_reg == '0) ? 5'd0 : 5'd1);
  end

  assign busy      = (state != lmp_pkg::ST_IDLE);
  assign cfg_ready = ~busy;
  assign cfg_write = cfg_valid & cfg_ready;
  assign accept    = start & ~busy;
  assign prop_go   = accept && (opcode == lmp_pkg::OP_PROP) && ({1'b0, col} < len_eff);
  assign in_range  = (int'(row) < MAX_VECTOR) && (int'(col) < MAX_VECTOR);

  // Matrix addresses: writes from the ports, reads by row of the latched column.
  assign wr_addr = AW'(int'(row) * MAX_VECTOR + int'(col));
  assign rd_addr = AW'(int'(k[3:1]) * MAX_VECTOR + int'(col_reg));

  // State register and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lmp_pkg::ST_IDLE;
      len_reg  <= lmp_pkg::LEN_RESET;
      col_reg  <= '0;
      k        <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        len_reg <= cfg_data;
      end
      if (prop_go) begin
        col_reg <= col;
      end
      if (state == lmp_pkg::ST_MAC) begin
        k <= k + 5'd1;
      end else begin
        k <= '0;
      end
      if (state == lmp_pkg::ST_EMIT) begin
        emit_idx <= emit_idx + 3'd1;
      end else begin
        emit_idx <= '0;
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      lmp_pkg::ST_IDLE: begin
        if (prop_go) state_next = lmp_pkg::ST_MAC;
      end
      lmp_pkg::ST_MAC: begin
        if (k == k_last) state_next = lmp_pkg::ST_DRAIN;
      end
      lmp_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = (col_reg == len_m1) ? lmp_pkg::ST_ROUND : lmp_pkg::ST_IDLE;
        end
      end
      lmp_pkg::ST_ROUND: begin
        state_next = lmp_pkg::ST_SQUARE;
      end
      lmp_pkg::ST_SQUARE: begin
        state_next = lmp_pkg::ST_SQ_DRAIN;
      end
      lmp_pkg::ST_SQ_DRAIN: begin
        if (!pipe_busy) state_next = lmp_pkg::ST_EMIT;
      end
      lmp_pkg::ST_EMIT: begin
        if (emit_idx == len_m1) state_next = lmp_pkg::ST_IDLE;
      end
      default: state_next = lmp_pkg::ST_IDLE;
    endcase
  end

  // Control word for the datapath.
  always_comb begin
    ctrl             = '0;
    ctrl.issue_kind  = lmp_pkg::K_DRIFT;
    ctrl.issue_row   = k[3:1];
    ctrl.emit_row    = emit_idx;
    ctrl.clear       = cfg_write;
    unique case (state)
      lmp_pkg::ST_IDLE: begin
        ctrl.t_we      = accept && (opcode == lmp_pkg::OP_DRIFT) && in_range;
        ctrl.s_we      = accept && (opcode == lmp_pkg::OP_NOISE) && in_range;
        ctrl.load_item = prop_go;
      end
      lmp_pkg::ST_MAC: begin
        ctrl.issue_valid = 1'b1;
        if (k == {len_eff, 1'b0}) begin
          ctrl.issue_kind = lmp_pkg::K_PSQ;
        end else begin
          ctrl.issue_kind = k[0] ? lmp_pkg::K_NOISE : lmp_pkg::K_DRIFT;
        end
      end
      lmp_pkg::ST_ROUND: begin
        ctrl.load_o0 = 1'b1;
      end
      lmp_pkg::ST_SQUARE: begin
        ctrl.issue_valid = 1'b1;
        ctrl.issue_kind  = lmp_pkg::K_O0SQ;
      end
      lmp_pkg::ST_EMIT: begin
        ctrl.emit_valid = 1'b1;
        ctrl.emit_last  = (emit_idx == len_m1);
        ctrl.clear      = (emit_idx == len_m1);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/lmp_datapath.sv
// Datapath: shared 32x32 multiplier, saturating row accumulators, rounding
// and result registers. Depends on lmp_pkg.
module lmp_datapath #(
  parameter int MAX_VECTOR = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lmp_pkg::lmp_ctrl_t                  ctrl,
  input  logic signed [lmp_pkg::MOM_W-1:0]    momentum,
  input  logic signed [lmp_pkg::NOISE_W-1:0]  noise,
  input  logic signed [lmp_pkg::COEFF_W-1:0]  t_data,
  input  logic signed [lmp_pkg::COEFF_W-1:0]  s_data,
  output logic                                pipe_busy,
  output logic                                result_valid,
  output logic [lmp_pkg::IDX_W-1:0]           index,
  output logic signed [lmp_pkg::MOM_W-1:0]    momentum_out,
  output logic signed [lmp_pkg::ACC_W-1:0]    energy_delta,
  output logic                                last
);

  localparam int LEN_CAP = (MAX_VECTOR < lmp_pkg::MAX_LEN) ? MAX_VECTOR : lmp_pkg::MAX_LEN;
  localparam int AI      = $clog2(LEN_CAP);

  logic signed [lmp_pkg::MOM_W-1:0]   p_reg;
  logic signed [lmp_pkg::NOISE_W-1:0] xi_reg;
  logic signed [lmp_pkg::MOM_W-1:0]   o0_reg;

  logic                      s1_valid, s2_valid;
  lmp_pkg::lmp_kind_t        s1_kind, s2_kind;
  logic [lmp_pkg::IDX_W-1:0] s1_row, s2_row;

  logic signed [31:0]                opa, opb;
  logic signed [lmp_pkg::ACC_W-1:0]  prod_c, prod, addend, acc_sum;
  logic signed [lmp_pkg::ACC_W-1:0]  acc [LEN_CAP];
  logic signed [lmp_pkg::ACC_W-1:0]  sq0, o0sq;
  logic [AI-1:0]                     acc_idx, emit_idx;

  assign pipe_busy = s1_valid | s2_valid;
  assign acc_idx   = s2_row[AI-1:0];
  assign emit_idx  = ctrl.emit_row[AI-1:0];

  // Operands of the shared multiplier, aligned with the matrix read data.
  always_comb begin
    case (s1_kind)
      lmp_pkg::K_DRIFT: begin
        opa = t_data;
        opb = p_reg;
      end
      lmp_pkg::K_NOISE: begin
        opa = s_data;
        opb = 32'(xi_reg);
      end
      lmp_pkg::K_PSQ: begin
        opa = p_reg;
        opb = p_reg;
      end
      default: begin
        opa = o0_reg;
        opb = o0_reg;
      end
    endcase
  end

  assign prod_c  = opa * opb;
  // The noise term is Q.42 and is brought to Q.46 before accumulation.
  assign addend  = (s2_kind == lmp_pkg::K_NOISE) ? (prod <<< 4) : prod;
  assign acc_sum = lmp_pkg::sat_add64(acc[acc_idx], addend);

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= ctrl.issue_valid;
      s2_valid <= s1_valid;
    end
  end

  // Operand latches, stage tags and the registered product.
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      p_reg  <= momentum;
      xi_reg <= noise;
    end
    if (ctrl.load_o0) begin
      o0_reg <= lmp_pkg::to_q16(acc[0]);
    end
    s1_kind <= ctrl.issue_kind;
    s1_row  <= ctrl.issue_row;
    s2_kind <= s1_kind;
    s2_row  <= s1_row;
    prod    <= prod_c;
    if (s2_valid && (s2_kind == lmp_pkg::K_O0SQ)) begin
      o0sq <= prod;
    end
  end

  // Row accumulators and the square of element zero.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < LEN_CAP; i++) begin
        acc[i] <= '0;
      end
      sq0 <= '0;
    end else if (s2_valid) begin
      if ((s2_kind == lmp_pkg::K_DRIFT) || (s2_kind == lmp_pkg::K_NOISE)) begin
        acc[acc_idx] <= acc_sum;
      end
      if (s2_kind == lmp_pkg::K_PSQ) begin
        sq0 <= prod;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.emit_valid;
    end
    index        <= ctrl.emit_row;
    momentum_out <= lmp_pkg::to_q16(acc[emit_idx]);
    energy_delta <= ctrl.emit_last ? (sq0 - o0sq) : '0;
    last         <= ctrl.emit_last;
  end

endmodule

FILE: src/langevin_momentum_propagator.sv
// Langevin momentum propagator: out = T*p + S*xi with one shared multiplier.
// A propagate item of element col keeps busy high while its 2L products (plus p squared
// for element zero) issue and drain, one product per cycle through the single 32x32
// multiplier; the final element then emits L results on consecutive cycles with no stall.
// Matrix writes and ignored items do not raise busy. Synchronous reset sets length 5
// and clears the accumulators; matrix contents are undefined until written.
`include "langevin_momentum_propagator_macros.svh"

module langevin_momentum_propagator #(
  parameter int MAX_VECTOR = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lmp_pkg::OP_W-1:0]            opcode,
  input  logic [lmp_pkg::IDX_W-1:0]           row,
  input  logic [lmp_pkg::IDX_W-1:0]           col,
  input  logic signed [lmp_pkg::COEFF_W-1:0]  coeff,
  input  logic signed [lmp_pkg::MOM_W-1:0]    momentum,
  input  logic signed [lmp_pkg::NOISE_W-1:0]  noise,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lmp_pkg::CFG_W-1:0]           cfg_data,
  output logic                                result_valid,
  output logic [lmp_pkg::IDX_W-1:0]           index,
  output logic signed [lmp_pkg::MOM_W-1:0]    momentum_out,
  output logic signed [lmp_pkg::ACC_W-1:0]    energy_delta,
  output logic                                last
);

  localparam int DEPTH = MAX_VECTOR * MAX_VECTOR;
  localparam int AW    = $clog2(DEPTH);

  lmp_pkg::lmp_ctrl_t          ctrl;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [lmp_pkg::COEFF_W-1:0] t_data, s_data;
  logic                        pipe_busy;

  // Sequencer.
  lmp_ctrl #(.MAX_VECTOR(MAX_VECTOR)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .row       (row),
    .col       (col),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .pipe_busy (pipe_busy),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .ctrl      (ctrl)
  );

  // Drift matrix storage.
  lmp_ram #(.WIDTH(lmp_pkg::COEFF_W), .DEPTH(DEPTH)) u_drift_ram (
    .clk     (clk),
    .we      (ctrl.t_we),
    .wr_addr (wr_addr),
    .wr_data (coeff),
    .rd_addr (rd_addr),
    .rd_data (t_data)
  );

  // Noise matrix storage.
  lmp_ram #(.WIDTH(lmp_pkg::COEFF_W), .DEPTH(DEPTH)) u_noise_ram (
    .clk     (clk),
    .we      (ctrl.s_we),
    .wr_addr (wr_addr),
    .wr_data (coeff),
    .rd_addr (rd_addr),
    .rd_data (s_data)
  );

  // Shared multiplier, accumulators and result registers.
  lmp_datapath #(.MAX_VECTOR(MAX_VECTOR)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .momentum     (momentum),
    .noise        (noise),
    .t_data       ($signed(t_data)),
    .s_data       ($signed(s_data)),
    .pipe_busy    (pipe_busy),
    .result_valid (result_valid),
    .index        (index),
    .momentum_out (momentum_out),
    .energy_delta (energy_delta),
    .last         (last)
  );

  // Results of one vector come on consecutive cycles and end with last.
  `LMP_ASSERT_NEXT(a_burst_continues, result_valid && !last, result_valid)
  `LMP_ASSERT_NEXT(a_burst_ends, result_valid && last, !result_valid)
  // The energy change is carried only by the final result.
  `LMP_ASSERT_SAME(a_energy_on_last, result_valid && !last, energy_delta == '0)

endmodule
